[rtl/twsm_pkg.sv]
package twsm_pkg;

   // request codes carried by req_type; any other code is a plain tick
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   localparam logic [4:0] ADDRESS_BITS  = 5'd8;
   localparam logic [4:0] XFER_BITS     = 5'd16;
   localparam logic [7:0] HALF_PERIOD_RESET = 8'd4;

endpackage

[rtl/three_wire_serial_master_unit.sv]
// Three-wire serial master (enable, clock, bidirectional data), LSB first. Every req item is
// one tick of the pin sequencer and returns exactly one rsp item that shows the pin levels,
// busy, done and the last read byte after that tick. A write (req_type 1) sends the address
// byte then the data byte; a read (req_type 2) sends the address byte, releases the data line
// and gathers 8 bits sampled on rising clock edges. Both shift 16 bits over the serial clock, each
// half period lasting csr_half_period_ticks ticks (0 acts as 1). Starts while busy are
// ignored. The block takes one item per cycle; req_stall rises only while the rsp register
// holds an item that the receiver is stalling. csr_ready is always high; write the half period
// while the block is idle.
module three_wire_serial_master_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_type,
   input  logic [7:0] req_address,
   input  logic [7:0] req_write_data,
   input  logic       req_data_pin_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_enable_pin,
   output logic       rsp_clock_pin,
   output logic       rsp_data_pin_out,
   output logic       rsp_data_drive,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic [7:0] rsp_read_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_half_period_ticks
);
   import twsm_pkg::*;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_READ  = 2'd2
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [4:0]  bit_count_ff, bit_count_in;
   logic [15:0] tx_shift_ff, tx_shift_in;
   logic [7:0]  rx_shift_ff, rx_shift_in;
   logic [7:0]  divider_count_ff, divider_count_in;
   logic        clock_level_ff, clock_level_in;
   logic [7:0]  received_byte_ff, received_byte_in;
   logic [7:0]  half_period_ff;

   logic        rsp_valid_ff;
   logic        rsp_enable_pin_ff, rsp_clock_pin_ff, rsp_data_pin_out_ff;
   logic        rsp_data_drive_ff, rsp_busy_res_ff, rsp_done_res_ff;
   logic [7:0]  rsp_read_data_ff;

   logic        accept;
   logic [7:0]  limit;
   logic [7:0]  divider_inc;
   logic [4:0]  bit_count_inc;
   logic        done_in;
   logic        busy_in;
   logic        receiving_in;
   logic        drive_in;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign limit         = (half_period_ff == 8'd0) ? 8'd1 : half_period_ff;
   assign divider_inc   = divider_count_ff + 8'd1;
   assign bit_count_inc = bit_count_ff + 5'd1;

   always_comb begin
      mode_in          = mode_ff;
      bit_count_in     = bit_count_ff;
      tx_shift_in      = tx_shift_ff;
      rx_shift_in      = rx_shift_ff;
      divider_count_in = divider_count_ff;
      clock_level_in   = clock_level_ff;
      received_byte_in = received_byte_ff;
      done_in          = 1'b0;
      if (mode_ff == MODE_IDLE) begin
         if (req_type == REQ_WRITE || req_type == REQ_READ) begin
            mode_in          = (req_type == REQ_WRITE) ? MODE_WRITE : MODE_READ;
            tx_shift_in      = (req_type == REQ_WRITE) ? {req_write_data, req_address}
                                                       : {8'd0, req_address};
            bit_count_in     = 5'd0;
            divider_count_in = 8'd0;
            clock_level_in   = 1'b0;
            rx_shift_in      = 8'd0;
         end
      end else begin
         divider_count_in = divider_inc;
         if (divider_inc >= limit) begin
            divider_count_in = 8'd0;
            if (!clock_level_ff) begin
               // rising edge: sample the data pin during the read data bits
               if (mode_ff == MODE_READ && bit_count_ff >= ADDRESS_BITS) begin
                  rx_shift_in = {req_data_pin_in, rx_shift_ff[7:1]};
               end
               clock_level_in = 1'b1;
            end else begin
               // falling edge: advance to the next bit
               clock_level_in = 1'b0;
               tx_shift_in    = {1'b0, tx_shift_ff[15:1]};
               bit_count_in   = bit_count_inc;
               if (bit_count_inc >= XFER_BITS) begin
                  if (mode_ff == MODE_READ) begin
                     received_byte_in = rx_shift_ff;
                  end
                  mode_in      = MODE_IDLE;
                  bit_count_in = 5'd0;
                  done_in      = 1'b1;
               end
            end
         end
      end
      busy_in      = (mode_in != MODE_IDLE);
      receiving_in = (mode_in == MODE_READ) && (bit_count_in >= ADDRESS_BITS);
      drive_in     = busy_in & ~receiving_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= MODE_IDLE;
         bit_count_ff     <= 5'd0;
         tx_shift_ff      <= 16'd0;
         rx_shift_ff      <= 8'd0;
         divider_count_ff <= 8'd0;
         clock_level_ff   <= 1'b0;
         received_byte_ff <= 8'd0;
         half_period_ff   <= HALF_PERIOD_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            half_period_ff <= csr_half_period_ticks;
         end
         if (accept) begin
            mode_ff          <= mode_in;
            bit_count_ff     <= bit_count_in;
            tx_shift_ff      <= tx_shift_in;
            rx_shift_ff      <= rx_shift_in;
            divider_count_ff <= divider_count_in;
            clock_level_ff   <= clock_level_in;
            received_byte_ff <= received_byte_in;
            rsp_valid_ff     <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         rsp_enable_pin_ff   <= busy_in;
         rsp_clock_pin_ff    <= clock_level_in;
         rsp_data_pin_out_ff <= drive_in & tx_shift_in[0];
         rsp_data_drive_ff   <= drive_in;
         rsp_busy_res_ff     <= busy_in;
         rsp_done_res_ff     <= done_in;
         rsp_read_data_ff    <= received_byte_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_enable_pin   = rsp_enable_pin_ff;
   assign rsp_clock_pin    = rsp_clock_pin_ff;
   assign rsp_data_pin_out = rsp_data_pin_out_ff;
   assign rsp_data_drive   = rsp_data_drive_ff;
   assign rsp_busy_res     = rsp_busy_res_ff;
   assign rsp_done_res     = rsp_done_res_ff;
   assign rsp_read_data    = rsp_read_data_ff;

`ifndef SYNTH
   a_idle_clock_low: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_IDLE) |-> (!clock_level_ff && bit_count_ff == 5'd0))
      else $error("serial clock or bit count left set while idle");

   a_bit_count_range: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_IDLE) |-> (bit_count_ff < XFER_BITS))
      else $error("bit count past end of transaction");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no rsp item");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_res_ff) |-> (!rsp_busy_res_ff && !rsp_clock_pin_ff))
      else $error("done item shows busy or clock high");
`endif

endmodule

[dv/three_wire_serial_master_unit_tb.sv]
`timescale 1ns / 1ps

module three_wire_serial_master_unit_tb;
   import twsm_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;  // spare code, acts as a plain tick
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int NUM_PHASES = 7;
   localparam logic [7:0] DRAIN_HALF = 8'd1;

   typedef enum logic [1:0] {SEQ_IDLE, SEQ_WRITE, SEQ_READ} seq_mode_type;
   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] address;
      logic [7:0] write_data;
      logic       pin;
   } req_item_type;

   typedef struct packed {
      logic       enable;
      logic       sclk;
      logic       dout;
      logic       drive;
      logic       busy;
      logic       done;
      logic [7:0] read_byte;
   } pins_type;

   typedef struct packed {
      req_item_type it;
      logic         wait_idle;
      logic         typed;
      pins_type     res;
   } dir_row_type;

   localparam int NUM_DIRECTED = 12;
   localparam dir_row_type DIRECTED [NUM_DIRECTED] = '{
      '{'{REQ_TICK,   8'h00, 8'h00, 1'b0}, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00}},
      '{'{REQ_UNUSED, 8'hFF, 8'hFF, 1'b1}, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00}},
      '{'{REQ_WRITE,  8'h00, 8'hFF, 1'b0}, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00}},
      '{'{REQ_READ,   8'hFF, 8'h00, 1'b1}, 1'b0, 1'b0, '0},
      '{'{REQ_TICK,   8'h00, 8'h00, 1'b1}, 1'b0, 1'b0, '0},
      '{'{REQ_WRITE,  8'hFF, 8'h00, 1'b1}, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00}},
      '{'{REQ_WRITE,  8'h00, 8'hFF, 1'b0}, 1'b0, 1'b0, '0},
      '{'{REQ_READ,   8'hFF, 8'hFF, 1'b1}, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00}},
      '{'{REQ_TICK,   8'hFF, 8'hFF, 1'b1}, 1'b0, 1'b0, '0},
      '{'{REQ_READ,   8'h00, 8'h00, 1'b0}, 1'b1, 1'b0, '0},
      '{'{REQ_WRITE,  8'hAA, 8'h55, 1'b1}, 1'b1, 1'b0, '0},
      '{'{REQ_TICK,   8'h00, 8'h00, 1'b0}, 1'b1, 1'b0, '0}
   };

   localparam logic [7:0] PHASE_HALF [NUM_PHASES] = '{8'd1, 8'd0, 8'd255, 8'd2, 8'd3, 8'd1, 8'd7};
   localparam idling_type PHASE_IDLING [NUM_PHASES] =
      '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE, IDLE_RECEIVER, IDLE_SENDER};
   localparam int PHASE_ITEMS [NUM_PHASES] = '{60, 60, 30, 60, 50, 50, 40};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_type = REQ_TICK;
   logic [7:0] req_address = 8'h00;
   logic [7:0] req_write_data = 8'h00;
   logic       req_data_pin_in = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_enable_pin;
   logic       rsp_clock_pin;
   logic       rsp_data_pin_out;
   logic       rsp_data_drive;
   logic       rsp_busy_res;
   logic       rsp_done_res;
   logic [7:0] rsp_read_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_half_period_ticks = HALF_PERIOD_RESET;

   // expected sequencer state
   logic [7:0]   half_ticks = HALF_PERIOD_RESET;
   seq_mode_type seq_mode = SEQ_IDLE;
   logic [4:0]   bit_cnt = '0;
   logic [15:0]  tx_bits = '0;
   logic [7:0]   rx_bits = '0;
   logic [7:0]   div_cnt = '0;
   logic         sclk = 1'b0;
   logic [7:0]   last_rx = '0;

   pins_type expected_pins [$];
   pins_type want;
   int       mismatches = 0;
   int       cycles = 0;
   int       gap_pct = 0;
   int       stall_pct = 0;

   three_wire_serial_master_unit i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_type              (req_type),
      .req_address           (req_address),
      .req_write_data        (req_write_data),
      .req_data_pin_in       (req_data_pin_in),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_enable_pin        (rsp_enable_pin),
      .rsp_clock_pin         (rsp_clock_pin),
      .rsp_data_pin_out      (rsp_data_pin_out),
      .rsp_data_drive        (rsp_data_drive),
      .rsp_busy_res          (rsp_busy_res),
      .rsp_done_res          (rsp_done_res),
      .rsp_read_data         (rsp_read_data),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_half_period_ticks (csr_half_period_ticks)
   );

   always #10 clock = ~clock;

   // advance the pin sequencer by one tick and return the pins after it
   function automatic void step_sequencer(input req_item_type it, output pins_type res);
      logic [7:0] lim;
      logic       finished;
      logic       drive;
      lim = (half_ticks == 8'd0) ? 8'd1 : half_ticks;
      finished = 1'b0;
      if (seq_mode == SEQ_IDLE) begin
         if (it.kind == REQ_WRITE || it.kind == REQ_READ) begin
            seq_mode = (it.kind == REQ_WRITE) ? SEQ_WRITE : SEQ_READ;
            tx_bits = (it.kind == REQ_WRITE) ? {it.write_data, it.address} : {8'h00, it.address};
            bit_cnt = '0;
            div_cnt = '0;
            sclk = 1'b0;
            rx_bits = '0;
         end
      end else begin
         div_cnt = div_cnt + 8'd1;
         if (div_cnt >= lim) begin
            div_cnt = '0;
            if (!sclk) begin
               if (seq_mode == SEQ_READ && bit_cnt >= ADDRESS_BITS)
                  rx_bits = {it.pin, rx_bits[7:1]};
               sclk = 1'b1;
            end else begin
               sclk = 1'b0;
               tx_bits = tx_bits >> 1;
               bit_cnt = bit_cnt + 5'd1;
               if (bit_cnt >= XFER_BITS) begin
                  if (seq_mode == SEQ_READ)
                     last_rx = rx_bits;
                  seq_mode = SEQ_IDLE;
                  bit_cnt = '0;
                  div_cnt = '0;
                  finished = 1'b1;
               end
            end
         end
      end
      // data line is released while idle and during the data bits of a read
      drive = (seq_mode != SEQ_IDLE) && !(seq_mode == SEQ_READ && bit_cnt >= ADDRESS_BITS);
      res.enable = seq_mode != SEQ_IDLE;
      res.sclk = sclk;
      res.dout = drive & tx_bits[0];
      res.drive = drive;
      res.busy = seq_mode != SEQ_IDLE;
      res.done = finished;
      res.read_byte = last_rx;
   endfunction

   function automatic void check_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s: expected %0h, got %0h", name, exp_val, act_val);
         mismatches++;
      end
   endfunction

   function automatic req_item_type random_request();
      req_item_type it;
      int           r;
      r = $urandom_range(99);
      if (r < 50)
         it.kind = REQ_TICK;
      else if (r < 55)
         it.kind = REQ_UNUSED;
      else if (r < 78)
         it.kind = REQ_WRITE;
      else
         it.kind = REQ_READ;
      it.address = 8'($urandom_range(255));
      it.write_data = 8'($urandom_range(255));
      it.pin = 1'($urandom_range(1));
      return it;
   endfunction

   task automatic set_idling(input idling_type mode);
      case (mode)
         IDLE_SENDER: begin
            gap_pct = 64;
            stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            gap_pct = 0;
            stall_pct = 64;
         end
         IDLE_BOTH: begin
            gap_pct = 15;
            stall_pct = 15;
         end
         default: begin
            gap_pct = 0;
            stall_pct = 0;
         end
      endcase
   endtask

   // present one item, hold it until taken, then log its expected pins
   task automatic send_item(input req_item_type it, input logic typed, input pins_type typed_res);
      pins_type res;
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= it.kind;
      req_address <= it.address;
      req_write_data <= it.write_data;
      req_data_pin_in <= it.pin;
      do @(posedge clock); while (req_stall);
      step_sequencer(it, res);
      expected_pins.push_back(typed ? typed_res : res);
   endtask

   task automatic drain_to_idle();
      req_item_type it;
      while (seq_mode != SEQ_IDLE) begin
         it = '{REQ_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)), 1'($urandom_range(1))};
         send_item(it, 1'b0, '0);
      end
   endtask

   // drop valid and let every outstanding item come back
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pins.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_half_period(input logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_half_period_ticks <= value;
      do @(posedge clock); while (!csr_ready);
      half_ticks = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // shorten the half period so a running transaction finishes quickly
   task automatic fast_drain();
      settle();
      write_half_period(DRAIN_HALF);
      drain_to_idle();
      settle();
   endtask

   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pins.size() == 0) begin
            $error("rsp item with no expectation pending");
            mismatches++;
         end else begin
            want = expected_pins.pop_front();
            check_field("enable_pin", 8'(want.enable), 8'(rsp_enable_pin));
            check_field("clock_pin", 8'(want.sclk), 8'(rsp_clock_pin));
            check_field("data_pin_out", 8'(want.dout), 8'(rsp_data_pin_out));
            check_field("data_drive", 8'(want.drive), 8'(rsp_data_drive));
            check_field("busy_res", 8'(want.busy), 8'(rsp_busy_res));
            check_field("done_res", 8'(want.done), 8'(rsp_done_res));
            check_field("read_data", want.read_byte, rsp_read_data);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_idling(IDLE_NONE);
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         if (DIRECTED[i].wait_idle)
            drain_to_idle();
         send_item(DIRECTED[i].it, DIRECTED[i].typed, DIRECTED[i].res);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         fast_drain();
         write_half_period(PHASE_HALF[p]);
         set_idling(PHASE_IDLING[p]);
         for (int n = 0; n < PHASE_ITEMS[p]; n++)
            send_item(random_request(), 1'b0, '0);
      end

      fast_drain();
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

[files.f]
rtl/twsm_pkg.sv
rtl/three_wire_serial_master_unit.sv
dv/three_wire_serial_master_unit_tb.sv
